### hw/rtl/tpeq_pkg.sv
// ----------------------------------------------------------------------------
// Three-level priority event queue package
// Sizes, request codes and status codes shared by the queue design.
// ----------------------------------------------------------------------------
package tpeq_pkg;

   // Events held per priority level.
   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_LEVELS  = 3;

   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEVEL_W     = 2;
   localparam int EVENT_W     = 64;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // Request kinds.
   localparam logic REQ_ADD     = 1'b0;
   localparam logic REQ_EXECUTE = 1'b1;

   // Priority codes carried by an add request.
   localparam logic [2:0] PRIO_HIGH   = 3'd1;
   localparam logic [2:0] PRIO_MEDIUM = 3'd2;
   localparam logic [2:0] PRIO_LOW    = 3'd3;

   // Result status codes.
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_EXECUTED = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

endpackage

### hw/rtl/tpeq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module tpeq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/three_level_priority_event_queue_top.sv
// ----------------------------------------------------------------------------
// Three-level strict priority event queue
// Three FIFO queues of pending events served in strict priority order.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge where start is high; busy never
// rises, so one request can be issued in every cycle. Each request produces
// exactly one result, shown on the rsp_ ports for one cycle with rsp_valid
// high, in the cycle right after the request is taken. The receiver cannot
// stall, so it must capture the result in that cycle. The result lags its
// request because the event RAM's read data is registered: the queue
// decision and the pointer updates are made in the request cycle, and the
// popped event arrives from the RAM together with the registered status.
// An add request (req_type 0) appends the event to the queue named by
// req_priority_req (1 high, 2 medium, 3 low). Any other priority code is
// answered with status 1 and stores nothing; a full queue is answered with
// status 2. An execute request (req_type 1) pops the oldest event of the
// highest non-empty queue and returns status 3 with its level and fields, or
// status 4 when all queues are empty. Fields not meaningful for a result
// read as zero. No clearing pass is needed after reset: only entries that
// were written are ever read, since the counters gate every pop.
// ----------------------------------------------------------------------------
module three_level_priority_event_queue_top
   import tpeq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [2:0]         req_priority_req,
   input  logic [15:0]        req_device_id,
   input  logic [15:0]        req_sensor_id,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [1:0]         rsp_served_level,
   output logic [15:0]        rsp_out_device_id,
   output logic [15:0]        rsp_out_sensor_id,
   output logic signed [31:0] rsp_out_value
);

   // Queue bookkeeping, one entry per level (level index 0 is high priority).
   ptr_type head_ff  [NUM_LEVELS];
   ptr_type tail_ff  [NUM_LEVELS];
   cnt_type count_ff [NUM_LEVELS];

   logic       rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   level_type  rsp_level_ff;

   logic       accept;
   logic       is_add;
   logic       prio_ok;
   level_type  add_lvl;
   logic       add_full;
   logic       do_write;
   logic       any_pending;
   level_type  pop_lvl;
   logic       do_read;
   logic [2:0] status_in;
   level_type  level_in;

   logic               ram_en;
   addr_type           ram_addr;
   logic [EVENT_W-1:0] ram_wdata;
   logic [EVENT_W-1:0] ram_rdata;

   // The queue takes a request in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_add = (req_type == REQ_ADD);

   // Map the priority code of an add request onto a level index.
   always_comb begin
      prio_ok = 1'b1;
      add_lvl = '0;
      unique case (req_priority_req)
         PRIO_HIGH:   add_lvl = level_type'(0);
         PRIO_MEDIUM: add_lvl = level_type'(1);
         PRIO_LOW:    add_lvl = level_type'(2);
         default:     prio_ok = 1'b0;
      endcase
   end

   assign add_full = prio_ok && (count_ff[add_lvl] == cnt_type'(QUEUE_DEPTH));
   assign do_write = accept && is_add && prio_ok && !add_full;

   // Strict priority: the first non-empty level wins.
   always_comb begin
      any_pending = 1'b0;
      pop_lvl     = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (count_ff[l] != '0) begin
            any_pending = 1'b1;
            pop_lvl     = level_type'(l);
         end
      end
   end

   assign do_read = accept && !is_add && any_pending;

   // Status of the result that leaves in the next cycle.
   always_comb begin
      level_in = '0;
      if (is_add) begin
         if (!prio_ok) begin
            status_in = ST_INVALID;
         end else if (add_full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ADDED;
         end
      end else if (any_pending) begin
         status_in = ST_EXECUTED;
         level_in  = pop_lvl + level_type'(1);
      end else begin
         status_in = ST_EMPTY;
      end
   end

   // Each level owns a slice of QUEUE_DEPTH entries in the event RAM.
   assign ram_en    = do_write || do_read;
   assign ram_addr  = is_add
                    ? addr_type'(32'(add_lvl) * QUEUE_DEPTH + 32'(tail_ff[add_lvl]))
                    : addr_type'(32'(pop_lvl) * QUEUE_DEPTH + 32'(head_ff[pop_lvl]));
   assign ram_wdata = {req_device_id, req_sensor_id, req_new_value};

   tpeq_ram #(
      .WIDTH(EVENT_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .en   (ram_en),
      .we   (is_add),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_ADDED;
         rsp_level_ff  <= '0;
      end else begin
         if (do_write) begin
            tail_ff[add_lvl]  <= (tail_ff[add_lvl] == ptr_type'(QUEUE_DEPTH - 1))
                               ? '0 : tail_ff[add_lvl] + ptr_type'(1);
            count_ff[add_lvl] <= count_ff[add_lvl] + cnt_type'(1);
         end
         if (do_read) begin
            head_ff[pop_lvl]  <= (head_ff[pop_lvl] == ptr_type'(QUEUE_DEPTH - 1))
                               ? '0 : head_ff[pop_lvl] + ptr_type'(1);
            count_ff[pop_lvl] <= count_ff[pop_lvl] - cnt_type'(1);
         end
         rsp_valid_ff <= accept;
         if (accept) begin
            rsp_status_ff <= status_in;
            rsp_level_ff  <= level_in;
         end
      end
   end

   // Event fields come straight from the RAM's read register on an execute.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_served_level  = rsp_level_ff;
   assign rsp_out_device_id = (rsp_status_ff == ST_EXECUTED) ? ram_rdata[63:48] : '0;
   assign rsp_out_sensor_id = (rsp_status_ff == ST_EXECUTED) ? ram_rdata[47:32] : '0;
   assign rsp_out_value     = (rsp_status_ff == ST_EXECUTED) ? ram_rdata[31:0] : '0;

   // Every accepted request yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request accepted without a result in the next cycle");

   // An executed event always names the level it came from.
   a_exec_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EXECUTED) |-> (rsp_served_level != '0))
      else $error("executed event without a served level");

   // An empty result never names a served level.
   a_empty_no_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_served_level == '0))
      else $error("nothing pending but a level was reported");

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level_chk
      // Occupancy never exceeds the queue depth.
      a_count_bound: assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= cnt_type'(QUEUE_DEPTH))
         else $error("queue occupancy above its depth");

      // An empty or a full queue has its head and tail on the same slot.
      a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
         (count_ff[g] == '0 || count_ff[g] == cnt_type'(QUEUE_DEPTH))
         |-> (head_ff[g] == tail_ff[g]))
         else $error("head and tail disagree with the occupancy");
   end

endmodule
